### hw/rtl/hrsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP response parser package
// Shared constants, codes and keyword tables of the response stream parser.
// ----------------------------------------------------------------------------
package hrsp_pkg;

    localparam int KEYWORD_MAX_DEFAULT = 18;

    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_PLUS = 8'h2B;

    localparam logic [2:0] EV_BODY       = 3'd0;
    localparam logic [2:0] EV_LAST       = 3'd1;
    localparam logic [2:0] EV_HDR_DONE   = 3'd2;
    localparam logic [2:0] EV_CHUNK_DONE = 3'd3;
    localparam logic [2:0] EV_LEN_ERR    = 3'd4;

    localparam logic [9:0] STATUS_MAX = 10'd999;
    localparam logic [9:0] STATUS_OK  = 10'd200;

    // Keyword candidate bits.
    localparam int KW_HTTP = 0;
    localparam int KW_CLEN = 1;
    localparam int KW_TENC = 2;
    localparam int KW_CONN = 3;

    typedef enum logic [6:0] {
        PH_HDR      = 7'b0000001,
        PH_PLAIN    = 7'b0000010,
        PH_SIZE     = 7'b0000100,
        PH_DATA     = 7'b0001000,
        PH_DATA_END = 7'b0010000,
        PH_TRAILER  = 7'b0100000,
        PH_IDLE     = 7'b1000000
    } phase_t;

    typedef enum logic [1:0] {
        TF_FIRST = 2'd0,
        TF_KEY   = 2'd1,
        TF_VALUE = 2'd2,
        TF_SKIP  = 2'd3
    } tfield_t;

    localparam logic [18*8-1:0] KW_TEXT_HTTP = "http";
    localparam logic [18*8-1:0] KW_TEXT_CLEN = "content-length:";
    localparam logic [18*8-1:0] KW_TEXT_TENC = "transfer-encoding:";
    localparam logic [18*8-1:0] KW_TEXT_CONN = "connection:";
    localparam logic [7*8-1:0]  WORD_CHUNKED = "chunked";
    localparam logic [7*8-1:0]  WORD_CLOSE   = "close";

    function automatic logic [4:0] kw_len(input logic [1:0] k);
        logic [4:0] l;
        case (k)
            2'd0: l = 5'd4;
            2'd1: l = 5'd15;
            2'd2: l = 5'd18;
            default: l = 5'd11;
        endcase
        return l;
    endfunction

    // Character i of keyword k, counted from the start of the keyword.
    function automatic logic [7:0] kw_byte(input logic [1:0] k, input logic [4:0] i);
        logic [18*8-1:0] t;
        logic [4:0] l;
        logic [4:0] sh;
        case (k)
            2'd0: t = KW_TEXT_HTTP;
            2'd1: t = KW_TEXT_CLEN;
            2'd2: t = KW_TEXT_TENC;
            default: t = KW_TEXT_CONN;
        endcase
        l = kw_len(k);
        sh = l - 5'd1 - i;
        return t[8*sh +: 8];
    endfunction

    function automatic logic [7:0] word_byte(input logic is_ch, input logic [2:0] i);
        logic [2:0] sh;
        logic [7*8-1:0] t;
        t = is_ch ? WORD_CHUNKED : WORD_CLOSE;
        sh = (is_ch ? 3'd6 : 3'd4) - i;
        return t[8*sh +: 8];
    endfunction

endpackage

### hw/rtl/hrsp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input channel interface
// Valid/ready channel carrying one received byte or a start marker.
// ----------------------------------------------------------------------------
interface hrsp_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

### hw/rtl/hrsp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel carrying one parser event with its context fields.
// ----------------------------------------------------------------------------
interface hrsp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  body_byte;
    logic [9:0]  status_code;
    logic [31:0] total_length;
    logic        is_chunked;
    logic        close_requested;
    logic [31:0] body_offset;

    modport source (output valid, output event_res, output body_byte, output status_code,
                    output total_length, output is_chunked, output close_requested,
                    output body_offset, input ready);
    modport sink (input valid, input event_res, input body_byte, input status_code,
                  input total_length, input is_chunked, input close_requested,
                  input body_offset, output ready);
endinterface

### hw/rtl/http_response_stream_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP response stream parser
// Decodes a response byte stream: header fields, plain and chunked bodies.
// ----------------------------------------------------------------------------
// Usage notes.
// The in_ch channel takes one transfer per received byte (kind = 0), or a
// start marker (kind = 1) which clears all parse state and yields no result.
// The out_ch channel delivers at most one event per input transfer: body
// bytes, header complete, chunked body complete or a length error, each with
// the captured status, length, flags and body offset.
// Each transfer is decoded in the cycle it is accepted and the event is held
// in the output register from the next cycle; the throughput is one byte per
// cycle while the receiver keeps up, set by the single state update path.
// When the receiver stalls, the output register holds its event and in_ch
// is not ready for as long as that event waits; in_ch is ready again in the
// cycle the receiver takes the event, so a new transfer can enter then.
// Reset (asynchronous, active low) puts the parser at the start of a header
// line with all captured values cleared and the output register empty.
// ----------------------------------------------------------------------------
module http_response_stream_parser_top
    import hrsp_pkg::*;
#(
    parameter int KEYWORD_MAX = KEYWORD_MAX_DEFAULT
)
(
    input  logic           clk,
    input  logic           rst_n,
    hrsp_in_if.sink        in_ch,
    hrsp_out_if.source     out_ch
);

    localparam int TPW = $clog2(KEYWORD_MAX + 1);

    typedef struct packed {
        phase_t          phase;
        logic [TPW-1:0]  pos;
        logic [3:0]      cand;
        tfield_t         tf;
        logic            cr;
        logic            line_empty;
        logic [31:0]     acc;
        logic [9:0]      status;
        logic [31:0]     length;
        logic            chunked;
        logic            close;
        logic [31:0]     rem;
        logic [31:0]     offset;
    } pstate_t;

    typedef struct packed {
        logic [2:0]  ev;
        logic [7:0]  data;
        logic [9:0]  status;
        logic [31:0] length;
        logic        chunked;
        logic        close;
        logic [31:0] offset;
    } result_t;

    pstate_t st_reg, st_next;
    result_t res_reg, res_next;
    logic    out_valid_reg;
    logic    emit;
    logic    accept;

    function automatic logic [7:0] lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic [31:0] mac10(input logic [31:0] a, input logic [3:0] d);
        logic [35:0] w;
        w = {1'b0, a, 3'b0} + {3'b0, a, 1'b0} + {32'd0, d};
        return (w[35:32] != 4'd0) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    function automatic logic [31:0] mac16(input logic [31:0] a, input logic [3:0] d);
        logic [35:0] w;
        w = {a, 4'b0} + {32'd0, d};
        return (w[35:32] != 4'd0) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    function automatic pstate_t new_line(input pstate_t s);
        pstate_t r;
        r = s;
        r.tf = TF_FIRST;
        r.pos = '0;
        r.cand = 4'hF;
        r.line_empty = 1'b1;
        r.cr = 1'b0;
        r.acc = '0;
        return r;
    endfunction

    function automatic pstate_t put_number(input pstate_t s);
        pstate_t r;
        r = s;
        if (s.cand[KW_HTTP])
            r.status = (s.acc > 32'(STATUS_MAX)) ? STATUS_MAX : s.acc[9:0];
        else
            r.length = s.acc;
        return r;
    endfunction

    function automatic pstate_t value_char(input pstate_t s, input logic [7:0] c);
        pstate_t r;
        logic    is_ch;
        logic [TPW-1:0] wl;
        r = s;
        is_ch = s.cand[KW_TENC];
        wl = is_ch ? TPW'(7) : TPW'(5);
        if (s.cand[KW_HTTP] || s.cand[KW_CLEN]) begin
            if (r.pos == '0) begin
                r.acc = '0;
                r = put_number(r);
                r.pos = TPW'(1);
                if (c == CH_PLUS)
                    return r;
            end
            if (c >= "0" && c <= "9") begin
                r.acc = mac10(r.acc, 4'(c - "0"));
                r = put_number(r);
            end else begin
                r.tf = TF_SKIP;
            end
        end else if (r.pos < wl && lower(c) == word_byte(is_ch, r.pos[2:0])) begin
            r.pos = r.pos + TPW'(1);
            if (r.pos == wl) begin
                if (is_ch)
                    r.chunked = 1'b1;
                else
                    r.close = 1'b1;
                r.tf = TF_SKIP;
            end
        end else begin
            r.tf = TF_SKIP;
        end
        return r;
    endfunction

    function automatic pstate_t hdr_char(input pstate_t s, input logic [7:0] c);
        pstate_t    r;
        logic       stop;
        logic [3:0] m;
        r = s;
        stop = (c == CH_LF) || (c == CH_NUL);
        r.line_empty = 1'b0;
        if (r.tf == TF_SKIP)
            return r;
        if (r.tf == TF_FIRST) begin
            if (c == CH_SP || c == CH_TAB)
                return r;
            if (stop) begin
                r.tf = TF_SKIP;
                return r;
            end
            r.tf = TF_KEY;
        end
        if (r.tf == TF_KEY) begin
            if (stop) begin
                r.tf = TF_SKIP;
                return r;
            end
            if (c == CH_SP) begin
                m = 4'd0;
                for (int k = 0; k < 4; k++) begin
                    if (r.cand[k] && r.pos >= TPW'(kw_len(2'(k))))
                        m = 4'(1 << k);
                end
                r.cand = m;
                r.tf = (m != 4'd0) ? TF_VALUE : TF_SKIP;
                r.pos = '0;
                return r;
            end
            for (int k = 0; k < 4; k++) begin
                if (r.pos < TPW'(kw_len(2'(k))) &&
                    lower(c) != kw_byte(2'(k), r.pos[4:0]))
                    r.cand[k] = 1'b0;
            end
            if (r.pos < TPW'(KEYWORD_MAX))
                r.pos = r.pos + TPW'(1);
            return r;
        end
        if (stop) begin
            r.tf = TF_SKIP;
            return r;
        end
        if (r.pos == '0 && (c == CH_SP || c == CH_TAB))
            return r;
        if (c == CH_SP) begin
            r.tf = TF_SKIP;
            return r;
        end
        return value_char(r, c);
    endfunction

    function automatic pstate_t size_char(input pstate_t s, input logic [7:0] c);
        pstate_t    r;
        logic [7:0] lc;
        logic       hv;
        logic [3:0] h;
        r = s;
        lc = lower(c);
        hv = 1'b1;
        h = 4'd0;
        if (c >= "0" && c <= "9")
            h = 4'(c - "0");
        else if (lc >= "a" && lc <= "f")
            h = 4'(lc - "a" + 8'd10);
        else
            hv = 1'b0;
        r.line_empty = 1'b0;
        if (r.tf == TF_FIRST) begin
            if (c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_VT ||
                c == CH_FF || c == CH_CR)
                return r;
            r.tf = TF_KEY;
        end
        if (r.tf == TF_KEY) begin
            if (hv)
                r.acc = mac16(r.acc, h);
            else
                r.tf = TF_SKIP;
        end
        return r;
    endfunction

    function automatic pstate_t line_char(input pstate_t s, input logic [7:0] c);
        pstate_t r;
        r = s;
        if (s.phase == PH_HDR)
            r = hdr_char(s, c);
        else if (s.phase == PH_SIZE)
            r = size_char(s, c);
        else
            r.line_empty = 1'b0;
        return r;
    endfunction

    function automatic pstate_t clear_all();
        pstate_t r;
        r = '0;
        r.phase = PH_HDR;
        r = new_line(r);
        return r;
    endfunction

    assign accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !out_valid_reg || out_ch.ready;

    // One transfer's worth of parsing: next state and the optional event.
    always_comb
    begin
        pstate_t    s;
        logic [7:0] c;
        logic       eol;
        logic       empty;
        logic [31:0] acc;
        logic [2:0] ev;
        logic [7:0] data;
        logic [31:0] offs;
        phase_t     ph;

        s = st_reg;
        c = in_ch.rx_byte;
        eol = 1'b0;
        emit = 1'b0;
        ev = EV_BODY;
        data = 8'd0;
        offs = st_reg.offset;
        empty = st_reg.line_empty;
        acc = st_reg.acc;
        ph = st_reg.phase;

        if (in_ch.kind) begin
            s = clear_all();
        end else begin
            unique case (st_reg.phase)
                PH_HDR, PH_SIZE, PH_DATA_END, PH_TRAILER:
                begin
                    if (s.cr) begin
                        s.cr = 1'b0;
                        if (c == CH_LF)
                            eol = 1'b1;
                        else
                            s = line_char(s, CH_CR);
                    end
                    if (!eol) begin
                        if (c == CH_CR)
                            s.cr = 1'b1;
                        else
                            s = line_char(s, c);
                    end else begin
                        // The stray CR case above cannot precede a line end.
                        s = new_line(s);
                        if (ph == PH_HDR) begin
                            if (empty) begin
                                if (s.chunked) begin
                                    s.length = '0;
                                    s.rem = '0;
                                    s.phase = (s.status == STATUS_OK) ? PH_SIZE : PH_IDLE;
                                end else begin
                                    s.rem = s.length;
                                    s.phase = (s.status == STATUS_OK) ? PH_PLAIN : PH_IDLE;
                                end
                                emit = 1'b1;
                                ev = EV_HDR_DONE;
                            end
                        end else if (ph == PH_SIZE) begin
                            if (empty) begin
                                s.phase = PH_IDLE;
                                emit = 1'b1;
                                ev = EV_CHUNK_DONE;
                            end else if (acc != '0) begin
                                s.rem = acc;
                                s.length = (s.length > ~acc) ? 32'hFFFF_FFFF : s.length + acc;
                                s.phase = PH_DATA;
                            end else begin
                                s.phase = PH_TRAILER;
                            end
                        end else if (ph == PH_DATA_END) begin
                            s.phase = PH_SIZE;
                        end else if (empty) begin
                            s.phase = PH_IDLE;
                            emit = 1'b1;
                            ev = EV_CHUNK_DONE;
                        end
                    end
                end
                PH_PLAIN:
                begin
                    if (s.rem == '0) begin
                        s.phase = PH_IDLE;
                        emit = 1'b1;
                        ev = EV_LEN_ERR;
                    end else begin
                        emit = 1'b1;
                        ev = (s.rem == 32'd1) ? EV_LAST : EV_BODY;
                        data = c;
                        if (s.offset != 32'hFFFF_FFFF)
                            s.offset = s.offset + 32'd1;
                        s.rem = s.rem - 32'd1;
                    end
                end
                PH_DATA:
                begin
                    emit = 1'b1;
                    ev = EV_BODY;
                    data = c;
                    if (s.offset != 32'hFFFF_FFFF)
                        s.offset = s.offset + 32'd1;
                    s.rem = s.rem - 32'd1;
                    if (s.rem == '0) begin
                        s.phase = PH_DATA_END;
                        s = new_line(s);
                    end
                end
                PH_IDLE:
                begin
                end
                default:
                begin
                end
            endcase
        end

        st_next = s;
        res_next.ev = ev;
        res_next.data = data;
        res_next.status = s.status;
        res_next.length = s.length;
        res_next.chunked = s.chunked;
        res_next.close = s.close;
        res_next.offset = offs;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg <= clear_all();
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                st_reg <= st_next;
                if (emit)
                    out_valid_reg <= 1'b1;
                else if (out_ch.ready)
                    out_valid_reg <= 1'b0;
            end else if (out_ch.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
            res_reg <= res_next;
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.event_res       = res_reg.ev;
    assign out_ch.body_byte       = res_reg.data;
    assign out_ch.status_code     = res_reg.status;
    assign out_ch.total_length    = res_reg.length;
    assign out_ch.is_chunked      = res_reg.chunked;
    assign out_ch.close_requested = res_reg.close;
    assign out_ch.body_offset     = res_reg.offset;

endmodule
